### design/iee_pkg.sv
package iee_pkg;

  // Pending operator codes
  typedef enum logic [2:0] {
    OP_PLUS    = 3'd0,
    OP_MINUS   = 3'd1,
    OP_TIMES   = 3'd2,
    OP_DIVIDE  = 3'd3,
    OP_UNKNOWN = 3'd4
  } op_e;

  // Control part of a token handed from front to back
  typedef struct packed {
    op_e  op;
    logic last;
  } tok_ctrl_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_EXEC = 3'd1,
    ST_MUL  = 3'd2,
    ST_DIV  = 3'd3,
    ST_DONE = 3'd4
  } back_state_e;

  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_TIMES  = 8'h2A;
  localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  function automatic op_e classify(input logic [7:0] c);
    op_e r;
    unique case (c)
      CHAR_PLUS:   r = OP_PLUS;
      CHAR_MINUS:  r = OP_MINUS;
      CHAR_TIMES:  r = OP_TIMES;
      CHAR_DIVIDE: r = OP_DIVIDE;
      default:     r = OP_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

### design/iee_front.sv
module iee_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                char_code_i,
  input  logic                      last_char_i,
  input  logic                      tok_ready_i,
  output logic                      tok_push_o,
  output logic [VALUE_WIDTH-1:0]    tok_num_o,
  output iee_pkg::tok_ctrl_t        tok_ctrl_o
);

  logic [VALUE_WIDTH-1:0] accum_q, accum_d, accum_next, digit_val;
  logic                   accept, is_digit, is_space;

  assign in_ready_o = tok_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_digit  = (char_code_i >= iee_pkg::CHAR_ZERO) && (char_code_i <= iee_pkg::CHAR_NINE);
  assign is_space  = (char_code_i == iee_pkg::CHAR_SPACE);
  assign digit_val = VALUE_WIDTH'(char_code_i[3:0]);

  // times ten as shift-add
  assign accum_next = is_digit ? ((accum_q << 3) + (accum_q << 1) + digit_val) : accum_q;

  assign tok_push_o      = accept && ((!is_digit && !is_space) || last_char_i);
  assign tok_num_o       = accum_next;
  assign tok_ctrl_o.op   = iee_pkg::classify(char_code_i);
  assign tok_ctrl_o.last = last_char_i;

  always_comb begin
    accum_d = accum_q;
    if (accept) begin
      accum_d = tok_push_o ? '0 : accum_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
    end else begin
      accum_q <= accum_d;
    end
  end

endmodule

### design/iee_fifo.sv
module iee_fifo #(
  parameter int DATA_WIDTH = 36,
  parameter int DEPTH      = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic                  not_full_o,
  input  logic                  pop_i,
  output logic                  not_empty_o,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign not_full_o  = (cnt_q != CntW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign rdata_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### design/iee_back.sv
module iee_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tok_valid_i,
  output logic                   tok_pop_o,
  input  logic [VALUE_WIDTH-1:0] tok_num_i,
  input  iee_pkg::tok_ctrl_t     tok_ctrl_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            value_o,
  output logic                   divide_by_zero_o
);

  localparam int W    = VALUE_WIDTH;
  localparam int CntW = $clog2(W);

  iee_pkg::back_state_e state_q, state_d;
  iee_pkg::op_e         pend_op_q, pend_op_d;
  iee_pkg::tok_ctrl_t   tctrl_q, tctrl_d;

  logic [W-1:0]    rsum_q, rsum_d, term_q, term_d, tnum_q, tnum_d;
  logic [W:0]      acc_q, acc_d;
  logic [W-1:0]    sh_q, sh_d, opb_q, opb_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d, zdiv_q, zdiv_d;
  logic            out_valid_q, out_valid_d, out_zdiv_q, out_zdiv_d;
  logic [31:0]     out_value_q, out_value_d;

  logic [W:0]      mul_acc, rem_sh, rem_sub;
  logic            q_bit, out_free, last_iter;
  logic [W-1:0]    q_next, total;
  logic [63:0]     total_ext;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_iter = (cnt_q == CntW'(W - 1));
  assign mul_acc   = opb_q[0] ? (acc_q + {1'b0, sh_q}) : acc_q;
  assign rem_sh    = {acc_q[W-1:0], sh_q[W-1]};
  assign rem_sub   = rem_sh - {1'b0, opb_q};
  assign q_bit     = (rem_sh >= {1'b0, opb_q});
  assign q_next    = {sh_q[W-2:0], q_bit};
  assign total     = rsum_q + term_q;
  assign total_ext = 64'($signed(total));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iee_pkg::ST_IDLE: begin
        if (tok_valid_i) state_d = iee_pkg::ST_EXEC;
      end
      iee_pkg::ST_EXEC: begin
        unique case (pend_op_q)
          iee_pkg::OP_TIMES:  state_d = iee_pkg::ST_MUL;
          iee_pkg::OP_DIVIDE: state_d = (tnum_q == '0) ? iee_pkg::ST_DONE : iee_pkg::ST_DIV;
          default:            state_d = iee_pkg::ST_DONE;
        endcase
      end
      iee_pkg::ST_MUL, iee_pkg::ST_DIV: begin
        if (last_iter) state_d = iee_pkg::ST_DONE;
      end
      iee_pkg::ST_DONE: begin
        if (!tctrl_q.last || out_free) state_d = iee_pkg::ST_IDLE;
      end
      default: state_d = iee_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tok_pop_o   = 1'b0;
    pend_op_d   = pend_op_q;
    tctrl_d     = tctrl_q;
    rsum_d      = rsum_q;
    term_d      = term_q;
    tnum_d      = tnum_q;
    acc_d       = acc_q;
    sh_d        = sh_q;
    opb_d       = opb_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    zdiv_d      = zdiv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_zdiv_d  = out_zdiv_q;
    unique case (state_q)
      iee_pkg::ST_IDLE: begin
        if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          tnum_d    = tok_num_i;
          tctrl_d   = tok_ctrl_i;
        end
      end
      iee_pkg::ST_EXEC: begin
        acc_d = '0;
        cnt_d = '0;
        unique case (pend_op_q)
          iee_pkg::OP_PLUS: begin
            rsum_d = total;
            term_d = tnum_q;
          end
          iee_pkg::OP_MINUS: begin
            rsum_d = total;
            term_d = '0 - tnum_q;
          end
          iee_pkg::OP_TIMES: begin
            sh_d  = term_q;
            opb_d = tnum_q;
          end
          iee_pkg::OP_DIVIDE: begin
            if (tnum_q == '0) begin
              term_d = '0;
              zdiv_d = 1'b1;
            end
            sh_d  = term_q[W-1] ? ('0 - term_q) : term_q;
            opb_d = tnum_q[W-1] ? ('0 - tnum_q) : tnum_q;
            neg_d = term_q[W-1] ^ tnum_q[W-1];
          end
          default: begin
            // unknown operator: drop the number
          end
        endcase
      end
      iee_pkg::ST_MUL: begin
        acc_d = mul_acc;
        sh_d  = sh_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (last_iter) term_d = mul_acc[W-1:0];
      end
      iee_pkg::ST_DIV: begin
        acc_d = q_bit ? rem_sub : rem_sh;
        sh_d  = q_next;
        cnt_d = cnt_q + 1'b1;
        if (last_iter) term_d = neg_q ? ('0 - q_next) : q_next;
      end
      iee_pkg::ST_DONE: begin
        pend_op_d = tctrl_q.op;
        if (tctrl_q.last && out_free) begin
          out_valid_d = 1'b1;
          out_value_d = total_ext[31:0];
          out_zdiv_d  = zdiv_q;
          rsum_d      = '0;
          term_d      = '0;
          zdiv_d      = 1'b0;
          pend_op_d   = iee_pkg::OP_PLUS;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = out_value_q;
  assign divide_by_zero_o = out_zdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iee_pkg::ST_IDLE;
      pend_op_q   <= iee_pkg::OP_PLUS;
      rsum_q      <= '0;
      term_q      <= '0;
      zdiv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      pend_op_q   <= pend_op_d;
      rsum_q      <= rsum_d;
      term_q      <= term_d;
      zdiv_q      <= zdiv_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tctrl_q     <= tctrl_d;
    tnum_q      <= tnum_d;
    acc_q       <= acc_d;
    sh_q        <= sh_d;
    opb_q       <= opb_d;
    neg_q       <= neg_d;
    out_value_q <= out_value_d;
    out_zdiv_q  <= out_zdiv_d;
  end

endmodule

### design/infix_expression_evaluator_core.sv
// Infix expression evaluator: integers joined by + - * / with precedence.
//
// Input channel (in_valid_i / in_ready_o): one ASCII character per word,
// last_char_i marks the final character of an expression. Output channel
// (out_valid_o / out_ready_i): one word per expression, the wrapped result
// in value_o and a sticky divide-by-zero flag.
//
// The front end takes one character per cycle while the queue has room,
// builds the number and pushes a token for every operator or final
// character into a small queue. The back end applies the pending operator:
// + - and unknown operators pass through the idle, exec and done states; * and
// / also run a shared shift-add / restoring-divide unit one bit per cycle,
// unless the divisor is zero. Digits and spaces push no token unless they
// are the final character. The result word is registered in the done
// state of the last token, once the queue has drained, after the multiply
// or divide of a final * or /. Reset clears the number, the sum, the term,
// the queue and the output valid flag; the pending operator returns to
// plus. When the receiver stalls, the result holds in the output register
// while the back end keeps working on the next expression until it needs
// that register again; the front end stalls once the queue is full.
module infix_expression_evaluator_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int FIFO_DEPTH  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o,
  output logic        divide_by_zero_o
);

  localparam int CtrlW = $bits(iee_pkg::tok_ctrl_t);
  localparam int TokW  = VALUE_WIDTH + CtrlW;

  logic                   push, not_full, not_empty, pop;
  logic [VALUE_WIDTH-1:0] push_num, head_num;
  iee_pkg::tok_ctrl_t     push_ctrl, head_ctrl;
  logic [TokW-1:0]        head_word;

  // front: classify characters, accumulate digits
  iee_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .tok_ready_i (not_full),
    .tok_push_o  (push),
    .tok_num_o   (push_num),
    .tok_ctrl_o  (push_ctrl)
  );

  // token queue decouples front and back
  iee_fifo #(
    .DATA_WIDTH (TokW),
    .DEPTH      (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wdata_i     ({push_num, push_ctrl}),
    .not_full_o  (not_full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .rdata_o     (head_word)
  );

  assign head_num  = head_word[TokW-1:CtrlW];
  assign head_ctrl = iee_pkg::tok_ctrl_t'(head_word[CtrlW-1:0]);

  // back: apply pending operators, emit results
  iee_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_valid_i      (not_empty),
    .tok_pop_o        (pop),
    .tok_num_i        (head_num),
    .tok_ctrl_i       (head_ctrl),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule
